@@ rtl/indexed_min_heap_decrease_key_core_defines.svh @@
// Assertion macros for the indexed min-heap core.
// Used by the top level; expects i_clk and i_rst_n in scope.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_CORE_DEFINES_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define IMH_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define IMH_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define IMH_ASSERT_IMP(lbl, ante, cons)
`define IMH_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

@@ rtl/imh_pkg.sv @@
`timescale 1ns / 1ps
// Request and response types, action and status codes of the heap core.
// No dependencies.
package imh_pkg;

    localparam int NODE_BITS = 10;
    localparam int NODE_IDS  = 1024;

    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_FULL    = 3'd2;
    localparam logic [2:0] ST_REMOVED = 3'd3;
    localparam logic [2:0] ST_NOT_LESS = 3'd4;

    typedef struct packed {
        logic [1:0]  action;
        logic [9:0]  node;
        logic [31:0] key;
        logic        clear_positions;
    } t_req;

    typedef struct packed {
        logic [9:0]  node_out;
        logic [31:0] key_out;
        logic [10:0] count_out;
        logic [2:0]  status;
    } t_rsp;

endpackage

@@ rtl/imh_heap_ram.sv @@
`timescale 1ns / 1ps
// Heap slot memory: one write port, two registered read ports.
// No dependencies.
module imh_heap_ram #(
    parameter int DEPTH = 1025,
    parameter int AW    = 11,
    parameter int DW    = 42
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr_a,
    input  logic [AW-1:0] i_raddr_b,
    output logic [DW-1:0] o_rdata_a,
    output logic [DW-1:0] o_rdata_b
);
    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

@@ rtl/imh_pos_ram.sv @@
`timescale 1ns / 1ps
// Node position memory: one write port, one registered read port.
// Depends on imh_pkg for the node id width.
module imh_pos_ram #(
    parameter int DW = 11
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [imh_pkg::NODE_BITS-1:0] i_waddr,
    input  logic [DW-1:0]                i_wdata,
    input  logic [imh_pkg::NODE_BITS-1:0] i_raddr,
    output logic [DW-1:0]                o_rdata
);
    logic [DW-1:0] r_mem [imh_pkg::NODE_IDS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ rtl/indexed_min_heap_decrease_key_core.sv @@
`timescale 1ns / 1ps
// Indexed binary min-heap with decrease-key, delete-minimum and clear.
// Depends on imh_pkg, imh_heap_ram, imh_pos_ram and the assertion macro header.
//
// Each request walks the heap one level at a time, in a read state and a compare
// state of a sequencer that reads, compares and writes back the slot memory. An
// insert climbs up from its slot. A delete lets the hole walk down from the root,
// and the last entry may then climb back up. After the response is registered the
// sequencer returns to idle, and only there is the next request taken. A clear
// that also forgets positions and the pass after reset both sweep the whole
// position memory, during which no request is taken.
`include "indexed_min_heap_decrease_key_core_defines.svh"
module indexed_min_heap_decrease_key_core #(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  imh_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output imh_pkg::t_rsp o_rsp
);
    localparam int SW = $clog2(CAPACITY + 2);
    localparam int HW = $clog2(CAPACITY + 1);
    localparam int CW = SW + 1;
    localparam int NB = imh_pkg::NODE_BITS;
    localparam int DW = NB + KEY_BITS;
    localparam logic [SW-1:0] SLOT_REMOVED = SW'(CAPACITY + 1);
    localparam logic [SW-1:0] CAP_SLOT = SW'(CAPACITY);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_INS_POS, S_INS_CHK, S_DEL_TOP, S_DN_RD, S_DN_CMP,
        S_UP_RD, S_UP_CMP, S_CLR, S_DONE
    } t_state;

    t_state r_state;
    logic [NB-1:0]       r_node;
    logic [KEY_BITS-1:0] r_key;
    logic [SW-1:0]       r_cnt, r_hole, r_last, r_pos;
    logic [CW-1:0]       r_child;
    logic                r_del;
    logic [NB-1:0]       r_clr_idx;
    logic [NB-1:0]       r_res_node;
    logic [31:0]         r_res_key;
    logic [2:0]          r_res_status;
    logic                r_out_valid;
    imh_pkg::t_rsp       r_out;

    logic                w_h_we, w_p_we;
    logic [HW-1:0]       w_h_waddr, w_h_ra, w_h_rb;
    logic [DW-1:0]       w_h_wdata, w_h_rd_a, w_h_rd_b;
    logic [NB-1:0]       w_p_waddr, w_p_ra;
    logic [SW-1:0]       w_p_wdata, w_p_rd;
    logic [63:0]         w_key_ext;
    logic [KEY_BITS-1:0] w_key_in, w_key_a, w_key_b;
    logic [NB-1:0]       w_node_a, w_node_b;
    logic                w_sel_b, w_up_move, w_final_pos;
    logic [CW-1:0]       w_child_pick;

    assign w_key_ext = 64'(i_req.key);
    assign w_key_in  = w_key_ext[KEY_BITS-1:0];
    assign w_key_a   = w_h_rd_a[KEY_BITS-1:0];
    assign w_key_b   = w_h_rd_b[KEY_BITS-1:0];
    assign w_node_a  = w_h_rd_a[DW-1:KEY_BITS];
    assign w_node_b  = w_h_rd_b[DW-1:KEY_BITS];
    assign w_sel_b   = w_key_a > w_key_b;
    assign w_child_pick = w_sel_b ? r_child + CW'(1) : r_child;
    assign w_up_move = w_key_a > r_key;
    assign w_final_pos = (!r_del || r_hole != r_last) && (int'(r_node) < CAPACITY);

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out;

    always_comb begin
        w_h_we    = 1'b0;
        w_h_waddr = r_hole[HW-1:0];
        w_h_wdata = {r_node, r_key};
        w_h_ra    = HW'(1);
        w_h_rb    = r_cnt[HW-1:0];
        w_p_we    = 1'b0;
        w_p_waddr = r_node;
        w_p_wdata = r_hole;
        w_p_ra    = i_req.node;
        unique case (r_state)
            S_INS_POS: begin
                w_h_ra = w_p_rd[HW-1:0];
            end
            S_DEL_TOP: begin
                w_p_we    = int'(w_node_a) < CAPACITY;
                w_p_waddr = w_node_a;
                w_p_wdata = SLOT_REMOVED;
            end
            S_DN_RD: begin
                w_h_ra = r_child[HW-1:0];
                w_h_rb = HW'(r_child + CW'(1));
            end
            S_DN_CMP: begin
                w_h_we    = 1'b1;
                w_h_wdata = w_sel_b ? w_h_rd_b : w_h_rd_a;
                w_p_we    = int'(w_sel_b ? w_node_b : w_node_a) < CAPACITY;
                w_p_waddr = w_sel_b ? w_node_b : w_node_a;
            end
            S_UP_RD: begin
                w_h_ra = HW'(r_hole >> 1);
                if (r_hole <= SW'(1)) begin
                    w_h_we = 1'b1;
                    w_p_we = w_final_pos;
                end
            end
            S_UP_CMP: begin
                w_h_we = 1'b1;
                if (w_up_move) begin
                    w_h_wdata = w_h_rd_a;
                    w_p_we    = int'(w_node_a) < CAPACITY;
                    w_p_waddr = w_node_a;
                end else begin
                    w_p_we = w_final_pos;
                end
            end
            S_INIT, S_CLR: begin
                w_p_we    = 1'b1;
                w_p_waddr = r_clr_idx;
                w_p_wdata = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_clr_idx   <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT: begin
                    r_clr_idx <= r_clr_idx + NB'(1);
                    if (&r_clr_idx) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_node <= i_req.node;
                        r_key  <= w_key_in;
                        unique case (i_req.action)
                            imh_pkg::ACT_INSERT: begin
                                r_res_node <= i_req.node;
                                r_res_key  <= 32'(w_key_in);
                                r_del      <= 1'b0;
                                if (int'(i_req.node) >= CAPACITY) begin
                                    r_res_status <= imh_pkg::ST_REMOVED;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= imh_pkg::ST_OK;
                                    r_state      <= S_INS_POS;
                                end
                            end
                            imh_pkg::ACT_DELETE: begin
                                if (r_cnt == '0) begin
                                    r_res_node   <= '0;
                                    r_res_key    <= '0;
                                    r_res_status <= imh_pkg::ST_EMPTY;
                                    r_del        <= 1'b0;
                                    r_state      <= S_DONE;
                                end else begin
                                    r_res_status <= imh_pkg::ST_OK;
                                    r_del        <= 1'b1;
                                    r_last       <= r_cnt;
                                    r_cnt        <= r_cnt - SW'(1);
                                    r_state      <= S_DEL_TOP;
                                end
                            end
                            imh_pkg::ACT_CLEAR: begin
                                r_res_node   <= i_req.node;
                                r_res_key    <= '0;
                                r_res_status <= imh_pkg::ST_OK;
                                r_del        <= 1'b0;
                                r_cnt        <= '0;
                                r_clr_idx    <= '0;
                                r_state      <= i_req.clear_positions ? S_CLR : S_DONE;
                            end
                            default: begin
                                r_res_node   <= i_req.node;
                                r_res_key    <= '0;
                                r_res_status <= imh_pkg::ST_OK;
                                r_del        <= 1'b0;
                                r_state      <= S_DONE;
                            end
                        endcase
                    end
                end
                S_INS_POS: begin
                    r_pos <= w_p_rd;
                    if (w_p_rd == SLOT_REMOVED) begin
                        r_res_status <= imh_pkg::ST_REMOVED;
                        r_state      <= S_DONE;
                    end else begin
                        r_state <= S_INS_CHK;
                    end
                end
                S_INS_CHK: begin
                    if (r_pos != '0 && r_pos <= r_cnt && w_node_a == r_node) begin
                        if (r_key >= w_key_a) begin
                            r_res_status <= imh_pkg::ST_NOT_LESS;
                            r_state      <= S_DONE;
                        end else begin
                            r_hole  <= r_pos;
                            r_state <= S_UP_RD;
                        end
                    end else if (r_cnt >= CAP_SLOT) begin
                        r_res_status <= imh_pkg::ST_FULL;
                        r_state      <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + SW'(1);
                        r_hole  <= r_cnt + SW'(1);
                        r_state <= S_UP_RD;
                    end
                end
                S_DEL_TOP: begin
                    r_res_node <= w_node_a;
                    r_res_key  <= 32'(w_key_a);
                    r_node     <= w_node_b;
                    r_key      <= w_key_b;
                    r_hole     <= SW'(1);
                    r_child    <= CW'(2);
                    r_state    <= S_DN_RD;
                end
                S_DN_RD: begin
                    r_state <= (r_child < CW'(r_last)) ? S_DN_CMP : S_UP_RD;
                end
                S_DN_CMP: begin
                    r_hole  <= SW'(w_child_pick);
                    r_child <= w_child_pick << 1;
                    r_state <= S_DN_RD;
                end
                S_UP_RD: begin
                    r_state <= (r_hole > SW'(1)) ? S_UP_CMP : S_DONE;
                end
                S_UP_CMP: begin
                    if (w_up_move) begin
                        r_hole  <= r_hole >> 1;
                        r_state <= S_UP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CLR: begin
                    r_clr_idx <= r_clr_idx + NB'(1);
                    if (&r_clr_idx) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.node_out  <= r_res_node;
                        r_out.key_out   <= r_res_key;
                        r_out.count_out <= 11'(r_cnt);
                        r_out.status    <= r_res_status;
                        r_out_valid     <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    imh_heap_ram #(
        .DEPTH(CAPACITY + 1),
        .AW   (HW),
        .DW   (DW)
    ) u_heap_ram (
        .i_clk    (i_clk),
        .i_we     (w_h_we),
        .i_waddr  (w_h_waddr),
        .i_wdata  (w_h_wdata),
        .i_raddr_a(w_h_ra),
        .i_raddr_b(w_h_rb),
        .o_rdata_a(w_h_rd_a),
        .o_rdata_b(w_h_rd_b)
    );

    imh_pos_ram #(
        .DW(SW)
    ) u_pos_ram (
        .i_clk  (i_clk),
        .i_we   (w_p_we),
        .i_waddr(w_p_waddr),
        .i_wdata(w_p_wdata),
        .i_raddr(w_p_ra),
        .o_rdata(w_p_rd)
    );

    `IMH_ASSERT_IMP(a_cnt_bound, 1'b1, r_cnt <= CAP_SLOT)
    `IMH_ASSERT_IMP(a_up_hole, r_state == S_UP_CMP, r_hole > SW'(1))
    `IMH_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, r_state != S_IDLE)
endmodule
